### design/lpd_pkg.sv
// Shared types and constants for the length-prefixed deframer.
// Depends on nothing; the deframer core imports it.
package lpd_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned WORD_W = 16;

    // Header: 16-bit length then 16-bit endpoint, both big-endian.
    localparam int unsigned HDR_BYTES = 4;
    localparam int unsigned HDR_CNT_W = $clog2(HDR_BYTES);
    localparam logic [HDR_CNT_W-1:0] HDR_LEN_HI = HDR_CNT_W'(0);
    localparam logic [HDR_CNT_W-1:0] HDR_LEN_LO = HDR_CNT_W'(1);
    localparam logic [HDR_CNT_W-1:0] HDR_EP_HI  = HDR_CNT_W'(2);
    localparam logic [HDR_CNT_W-1:0] HDR_EP_LO  = HDR_CNT_W'(3);

    localparam logic [WORD_W-1:0] MAX_LEN_RESET = WORD_W'(8 * 1024);

    // Result status codes, carried on tuser.
    localparam logic STATUS_PAYLOAD   = 1'b0;
    localparam logic STATUS_OVERSIZED = 1'b1;

    // One result transaction as packed on the master-side tdata.
    typedef struct packed {
        logic [WORD_W-1:0] frame_length;
        logic [WORD_W-1:0] frame_endpoint;
        logic [BYTE_W-1:0] payload_byte;
    } lpd_result_t;

    localparam int unsigned RESULT_W = $bits(lpd_result_t);

endpackage

### design/length_prefixed_deframer_core.sv
// Length-prefixed deframer core: splits a byte stream into framed payload bytes.
// Depends on lpd_pkg for field widths, header byte codes and the result layout.
//
// The slave-side channel carries one received byte per transaction; s_tlast marks
// the last byte the link currently has buffered. Each frame opens with a four-byte
// header, a big-endian payload length and then a big-endian endpoint number. The
// master-side channel emits one transaction per payload byte, tagged with the
// frame's endpoint and length; m_tlast marks the final byte of a frame and m_tuser
// is zero. A zero-length header produces nothing. A length above the configured
// maximum produces one transaction with m_tuser set and a zero data byte, after
// which input bytes are dropped up to and including the next byte with s_tlast set.
// The cfg channel writes the maximum payload length (8192 after reset); write it
// only while no transaction is in flight.
// Timing: an accepted byte is decoded from the input register and its result is
//   registered in the output register that drives m_tvalid. One byte is accepted
//   every cycle while s_tready stays high.
// Reset (synchronous aresetn) clears both valid flags and restarts header parsing.
// When m_tready is low the pending result holds; bytes that give no result keep
// flowing, and s_tready drops while a byte that needs a result waits behind it.
module length_prefixed_deframer_core
    import lpd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    // Received bytes.
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [BYTE_W-1:0]   s_tdata,    // [7:0] rx_byte
    input  logic                s_tlast,    // burst_end

    // Deframed payload bytes and error reports.
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [RESULT_W-1:0] m_tdata,    // [7:0] payload_byte, [23:8] frame_endpoint,
                                            // [39:24] frame_length
    output logic                m_tlast,    // is_last
    output logic                m_tuser,    // status

    // Maximum payload length register.
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [WORD_W-1:0]   cfg_data
);

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_DISCARD = 2'd2;

    // Configuration register.
    logic [WORD_W-1:0] max_len_reg;

    // Input register.
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;

    // Parser state.
    logic [1:0]           phase_reg,    phase_next;
    logic [HDR_CNT_W-1:0] hdr_cnt_reg,  hdr_cnt_next;
    logic [WORD_W-1:0]    length_reg,   length_next;
    logic [WORD_W-1:0]    endpoint_reg, endpoint_next;
    logic [WORD_W-1:0]    left_reg,     left_next;

    // Output register.
    logic        out_valid_reg;
    lpd_result_t out_data_reg;
    logic        out_last_reg;
    logic        out_status_reg;

    // Decode results for the byte in the input register.
    logic        produce;
    lpd_result_t res_data;
    logic        res_last;
    logic        res_status;

    logic out_free;
    logic advance;
    logic in_take;

    assign cfg_ready = 1'b1;

    always_comb begin
        phase_next    = phase_reg;
        hdr_cnt_next  = hdr_cnt_reg;
        length_next   = length_reg;
        endpoint_next = endpoint_reg;
        left_next     = left_reg;
        produce       = 1'b0;
        res_last      = 1'b0;
        res_status    = STATUS_PAYLOAD;
        res_data.payload_byte = in_byte_reg;

        case (phase_reg)
            PH_DISCARD: begin
                if (in_last_reg) begin
                    phase_next = PH_HEADER;
                end
            end
            PH_PAYLOAD: begin
                produce  = 1'b1;
                res_last = (left_reg <= WORD_W'(1));
                if (res_last) begin
                    left_next  = '0;
                    phase_next = PH_HEADER;
                end else begin
                    left_next = left_reg - WORD_W'(1);
                end
            end
            default: begin
                // Header bytes; the unused phase code is handled the same way.
                phase_next   = PH_HEADER;
                hdr_cnt_next = hdr_cnt_reg + HDR_CNT_W'(1);
                case (hdr_cnt_reg)
                    HDR_LEN_HI: length_next   = {in_byte_reg, length_reg[BYTE_W-1:0]};
                    HDR_LEN_LO: length_next   = {length_reg[WORD_W-1:BYTE_W], in_byte_reg};
                    HDR_EP_HI:  endpoint_next = {in_byte_reg, endpoint_reg[BYTE_W-1:0]};
                    default:    endpoint_next = {endpoint_reg[WORD_W-1:BYTE_W], in_byte_reg};
                endcase
                if (hdr_cnt_reg == HDR_EP_LO && length_next != '0) begin
                    if (length_next > max_len_reg) begin
                        // Oversized frame: report once, then drop the rest of the burst
                        // unless this byte already ended it.
                        produce               = 1'b1;
                        res_status            = STATUS_OVERSIZED;
                        res_data.payload_byte = '0;
                        phase_next            = in_last_reg ? PH_HEADER : PH_DISCARD;
                    end else begin
                        left_next  = length_next;
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
        endcase

        res_data.frame_endpoint = endpoint_next;
        res_data.frame_length   = length_next;
    end

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!produce || out_free);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg   <= MAX_LEN_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_HEADER;
            hdr_cnt_reg   <= '0;
            length_reg    <= '0;
            endpoint_reg  <= '0;
            left_reg      <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                max_len_reg <= cfg_data;
            end

            if (in_take) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                phase_reg    <= phase_next;
                hdr_cnt_reg  <= hdr_cnt_next;
                length_reg   <= length_next;
                endpoint_reg <= endpoint_next;
                left_reg     <= left_next;
            end

            if (out_free) begin
                out_valid_reg <= advance && produce;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (out_free && advance && produce) begin
            out_data_reg   <= res_data;
            out_last_reg   <= res_last;
            out_status_reg <= res_status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_status_reg;

endmodule

### verif/length_prefixed_deframer_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for length_prefixed_deframer_core: random framed byte streams,
// a behavioral deframer that predicts every result, and randomized stream back-pressure.
// Depends on lpd_pkg and the deframer core RTL only.
module length_prefixed_deframer_core_tb;
    import lpd_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int PHASE_ITEMS    = 290;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_DISCARD = 2'd2
    } rx_phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              burst_end;
    } rx_item_t;

    typedef struct packed {
        lpd_result_t data;
        logic        last;
        logic        status;
    } frame_beat_t;

    logic                aclk;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [BYTE_W-1:0]   s_tdata   = '0;
    logic                s_tlast   = 1'b0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [RESULT_W-1:0] m_tdata;
    logic                m_tlast;
    logic                m_tuser;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [WORD_W-1:0]   cfg_data  = '0;

    rx_item_t    rx_queue[$];
    frame_beat_t expected_beats[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int fail_count     = 0;
    int quiet_cycles   = 0;

    // Shadow of the deframer's parser state and its length limit.
    rx_phase_t            rx_phase     = PH_HEADER;
    logic [HDR_CNT_W-1:0] hdr_count    = HDR_LEN_HI;
    logic [WORD_W-1:0]    hdr_length   = '0;
    logic [WORD_W-1:0]    hdr_endpoint = '0;
    logic [WORD_W-1:0]    bytes_left   = '0;
    logic [WORD_W-1:0]    max_len_cfg  = MAX_LEN_RESET;

    length_prefixed_deframer_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Advances the shadow parser by one received byte; returns 1 when the byte yields a result.
    function automatic bit deframe_byte(input logic [BYTE_W-1:0] rx_byte, input logic burst_end,
                                        output frame_beat_t beat);
        beat.data   = '0;
        beat.last   = 1'b0;
        beat.status = STATUS_PAYLOAD;
        case (rx_phase)
            PH_DISCARD: begin
                // Everything up to and including the end of the burst is dropped.
                if (burst_end)
                    rx_phase = PH_HEADER;
                return 1'b0;
            end
            PH_PAYLOAD: begin
                beat.data.payload_byte   = rx_byte;
                beat.data.frame_endpoint = hdr_endpoint;
                beat.data.frame_length   = hdr_length;
                beat.last                = (bytes_left <= 1);
                if (beat.last) begin
                    bytes_left = '0;
                    rx_phase   = PH_HEADER;
                end else begin
                    bytes_left = bytes_left - 1'b1;
                end
                return 1'b1;
            end
            default: begin
                rx_phase = PH_HEADER;
                case (hdr_count)
                    HDR_LEN_HI: hdr_length[15:8]   = rx_byte;
                    HDR_LEN_LO: hdr_length[7:0]    = rx_byte;
                    HDR_EP_HI:  hdr_endpoint[15:8] = rx_byte;
                    default:    hdr_endpoint[7:0]  = rx_byte;
                endcase
                hdr_count = hdr_count + 1'b1;
                // Nothing happens until the header is complete, and an empty frame is skipped.
                if (hdr_count != HDR_LEN_HI || hdr_length == '0)
                    return 1'b0;
                if (hdr_length > max_len_cfg) begin
                    beat.data.frame_endpoint = hdr_endpoint;
                    beat.data.frame_length   = hdr_length;
                    beat.status              = STATUS_OVERSIZED;
                    rx_phase                 = burst_end ? PH_HEADER : PH_DISCARD;
                    return 1'b1;
                end
                bytes_left = hdr_length;
                rx_phase   = PH_PAYLOAD;
                return 1'b0;
            end
        endcase
    endfunction

    // Sender: presents queued bytes, holds them under back-pressure, idles at random.
    always @(posedge aclk) begin : drive_rx
        frame_beat_t beat;
        rx_item_t    item;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (deframe_byte(s_tdata, s_tlast, beat))
                    expected_beats.push_back(beat);
            end
            if (!s_tvalid || s_tready) begin
                if (rx_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    item = rx_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= item.rx_byte;
                    s_tlast  <= item.burst_end;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: compares every result transaction with the oldest prediction.
    always @(posedge aclk) begin : check_results
        frame_beat_t want;
        lpd_result_t got;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = lpd_result_t'(m_tdata);
                if (expected_beats.size() == 0) begin
                    $error("result with nothing expected: tdata %h tlast %b tuser %b",
                           m_tdata, m_tlast, m_tuser);
                    fail_count++;
                end else begin
                    want = expected_beats.pop_front();
                    if (got.payload_byte !== want.data.payload_byte) begin
                        $error("payload_byte: expected %h, got %h",
                               want.data.payload_byte, got.payload_byte);
                        fail_count++;
                    end
                    if (got.frame_endpoint !== want.data.frame_endpoint) begin
                        $error("frame_endpoint: expected %h, got %h",
                               want.data.frame_endpoint, got.frame_endpoint);
                        fail_count++;
                    end
                    if (got.frame_length !== want.data.frame_length) begin
                        $error("frame_length: expected %h, got %h",
                               want.data.frame_length, got.frame_length);
                        fail_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("is_last: expected %b, got %b", want.last, m_tlast);
                        fail_count++;
                    end
                    if (m_tuser !== want.status) begin
                        $error("status: expected %b, got %b", want.status, m_tuser);
                        fail_count++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // A run that stops moving on any channel is a failure.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic push_byte(input logic [BYTE_W-1:0] rx_byte, input logic burst_end);
        rx_item_t item;
        item.rx_byte   = rx_byte;
        item.burst_end = burst_end;
        rx_queue.push_back(item);
    endtask

    // Big-endian length then endpoint; flags[i] is the burst_end bit of header byte i.
    task automatic push_header(input logic [WORD_W-1:0] length, input logic [WORD_W-1:0] endpoint,
                               input logic [3:0] flags);
        push_byte(length[15:8], flags[0]);
        push_byte(length[7:0], flags[1]);
        push_byte(endpoint[15:8], flags[2]);
        push_byte(endpoint[7:0], flags[3]);
    endtask

    // Stray burst_end flags outside discard must be ignored, so sprinkle some in.
    function automatic logic [3:0] stray_flags();
        return ($urandom_range(7) == 0) ? 4'($urandom_range(15)) : 4'b0000;
    endfunction

    function automatic logic [WORD_W-1:0] random_endpoint();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return WORD_W'($urandom_range(65535));
        endcase
    endfunction

    // Mostly well-formed frames; some empty and oversized headers, and stray bytes
    // that knock the parser out of header alignment.
    task automatic push_random_traffic(input int n_items);
        int         produced;
        int         pick;
        int         len;
        int         cap;
        int         n_drop;
        logic [3:0] flags;
        produced = 0;
        while (produced < n_items) begin
            pick = $urandom_range(99);
            if (pick < 5) begin
                push_byte(BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
                produced += 1;
            end else if (pick < 12) begin
                push_header('0, random_endpoint(), stray_flags());
                produced += 4;
            end else if ((pick < 27 && max_len_cfg != '1) || max_len_cfg == '0) begin
                if (pick < 17 || max_len_cfg == 16'hFFFE)
                    len = int'(max_len_cfg) + 1;
                else if (pick < 20)
                    len = 65535;
                else
                    len = $urandom_range(int'(max_len_cfg) + 1, 65535);
                flags = stray_flags();
                flags[3] = ($urandom_range(4) == 0);
                push_header(WORD_W'(len), random_endpoint(), flags);
                produced += 4;
                if (!flags[3]) begin
                    n_drop = $urandom_range(5);
                    repeat (n_drop)
                        push_byte(BYTE_W'($urandom_range(255)), 1'b0);
                    push_byte(BYTE_W'($urandom_range(255)), 1'b1);
                end
            end else begin
                cap = (max_len_cfg < 16) ? int'(max_len_cfg) : 16;
                len = $urandom_range(1, cap);
                if ($urandom_range(9) == 0)
                    len = cap;
                if ($urandom_range(39) == 0)
                    len = $urandom_range(1, (max_len_cfg < 300) ? int'(max_len_cfg) : 300);
                push_header(WORD_W'(len), random_endpoint(), stray_flags());
                repeat (len)
                    push_byte(BYTE_W'($urandom_range(255)), ($urandom_range(7) == 0));
                produced += 4 + len;
            end
        end
    endtask

    // Waits until every queued byte is taken and every result has come back.
    task automatic wait_until_drained();
        while (rx_queue.size() != 0 || s_tvalid || expected_beats.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_max_length(input logic [WORD_W-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge aclk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid   <= 1'b0;
        max_len_cfg  = value;
    endtask

    task automatic run_random_phase(input logic [WORD_W-1:0] max_len, input int send_pct,
                                    input int recv_pct);
        write_max_length(max_len);
        @(negedge aclk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        push_random_traffic(PHASE_ITEMS);
        wait_until_drained();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed frames at the reset limit, with no idling on either side.
        // Single-byte frame at the top endpoint, burst_end set on every byte.
        push_header(16'd1, 16'hFFFF, 4'b1111);
        push_byte(8'hFF, 1'b1);
        // Empty frame: skipped without a result.
        push_header(16'd0, 16'h1234, 4'b0000);
        // Two-byte frame at endpoint zero.
        push_header(16'd2, 16'h0000, 4'b0000);
        push_byte(8'h00, 1'b0);
        push_byte(8'h80, 1'b0);
        // Largest length: error, then drop bytes through the end of the burst.
        push_header(16'hFFFF, 16'hABCD, 4'b0000);
        push_byte(8'h5A, 1'b0);
        push_byte(8'hA5, 1'b1);
        // One past the limit with the burst ending on the header itself.
        push_header(MAX_LEN_RESET + 1'b1, 16'h00FF, 4'b1000);
        wait_until_drained();

        run_random_phase(16'd1, 81, 0);
        run_random_phase(16'hFFFF, 0, 81);
        run_random_phase(16'd0, 21, 21);
        run_random_phase(WORD_W'($urandom_range(2, 64)), 0, 0);
        run_random_phase(WORD_W'($urandom_range(1, 65535)), 21, 21);

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
